>>> rtl/brl_pkg.sv
// Shared widths, codes and item types for the run-slicing line generator.
`default_nettype none

package brl_pkg;

   // Coordinate width; spans and run lengths need one more bit, the error two more.
   localparam int COORD_BITS = 16;
   localparam int SPAN_BITS  = COORD_BITS + 1;
   localparam int ERR_BITS   = COORD_BITS + 2;
   localparam int COLOR_BITS = 16;

   // Item kinds on the request channel.
   typedef enum logic {
      KIND_START = 1'b0,
      KIND_STEP  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                       kind;
      logic signed [COORD_BITS-1:0]   start_x;
      logic signed [COORD_BITS-1:0]   start_y;
      logic signed [COORD_BITS-1:0]   end_x;
      logic signed [COORD_BITS-1:0]   end_y;
      logic        [COLOR_BITS-1:0]   line_color;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]   run_x;
      logic signed [COORD_BITS-1:0]   run_y;
      logic        [SPAN_BITS-1:0]    run_width;
      logic        [SPAN_BITS-1:0]    run_height;
      logic        [COLOR_BITS-1:0]   run_color;
      logic                           last_run;
   } rsp_type;

   // Handshake between the input register and the line engine.
   typedef struct packed {
      logic    valid;
      req_type item;
   } stage_type;

endpackage

`default_nettype wire

>>> rtl/brl_in_reg.sv
// Input register that holds one request item until the line engine takes it.
`default_nettype none

module brl_in_reg (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  wire brl_pkg::req_type req_item,
   input  wire              advance,
   output brl_pkg::stage_type stage
);

   logic             valid_ff;
   logic             valid_in;
   brl_pkg::req_type item_ff;
   logic             take;

   // A new item is taken whenever the register is empty or drains this cycle.
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads only on a take, so it holds while the engine waits.
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

`default_nettype wire

>>> rtl/brl_engine.sv
// Line state, per-item setup and step arithmetic, and the result register.
`default_nettype none

module brl_engine (
   input  wire                 clock,
   input  wire                 reset,
   input  wire brl_pkg::stage_type stage,
   output logic                advance,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output brl_pkg::rsp_type    rsp_item
);

   localparam int W = brl_pkg::COORD_BITS;
   localparam int S = brl_pkg::SPAN_BITS;
   localparam int E = brl_pkg::ERR_BITS;

   // Line state.
   logic                  active_ff, active_in;
   logic                  steep_ff, steep_in;
   logic signed [S-1:0]   major_pos_ff, major_pos_in;
   logic signed [S-1:0]   major_end_ff, major_end_in;
   logic signed [S-1:0]   minor_pos_ff, minor_pos_in;
   logic                  minor_dir_ff, minor_dir_in;
   logic        [S-1:0]   major_span_ff, major_span_in;
   logic        [S-1:0]   minor_span_ff, minor_span_in;
   logic signed [E-1:0]   error_ff, error_in;
   logic signed [S-1:0]   run_origin_ff, run_origin_in;
   logic        [S-1:0]   run_count_ff, run_count_in;
   logic [brl_pkg::COLOR_BITS-1:0] color_ff, color_in;

   // Result register.
   logic                  out_valid_ff, out_valid_in;
   brl_pkg::rsp_type      out_item_ff, out_item_in;

   // Setup terms for a start item.
   logic signed [S-1:0]   ax, ay, bx, by;
   logic signed [S-1:0]   dx, dy;
   logic        [S-1:0]   abs_dx, abs_dy;
   logic                  steep;
   logic signed [S-1:0]   maj_a, maj_b, min_a, min_b, maj_d, min_d;
   logic                  swap;

   // Step terms.
   logic signed [S-1:0]   major_next;
   logic        [S-1:0]   count_next;
   logic signed [E-1:0]   err_sub;
   logic                  ended;
   logic                  emit;

   // The engine takes an item whenever the result register is free or drains.
   assign advance      = stage.valid && (!out_valid_ff || !rsp_stall);

   // Endpoint differences, one bit wider than the coordinates.
   assign ax     = {stage.item.start_x[W-1], stage.item.start_x};
   assign ay     = {stage.item.start_y[W-1], stage.item.start_y};
   assign bx     = {stage.item.end_x[W-1], stage.item.end_x};
   assign by     = {stage.item.end_y[W-1], stage.item.end_y};
   assign dx     = bx - ax;
   assign dy     = by - ay;
   assign abs_dx = dx[S-1] ? S'(-dx) : S'(dx);
   assign abs_dy = dy[S-1] ? S'(-dy) : S'(dy);
   assign steep  = abs_dy > abs_dx;

   // Pick the major axis, then order the endpoints along it.
   assign maj_a  = steep ? ay : ax;
   assign maj_b  = steep ? by : bx;
   assign min_a  = steep ? ax : ay;
   assign min_b  = steep ? bx : by;
   assign maj_d  = steep ? dy : dx;
   assign min_d  = steep ? dx : dy;
   assign swap   = maj_d[S-1];

   // One pixel along the major axis; the error drops by the minor span.
   assign major_next = major_pos_ff + S'(1);
   assign count_next = run_count_ff + S'(1);
   assign err_sub    = error_ff - E'(minor_span_ff);
   assign ended      = major_pos_ff >= major_end_ff;
   assign emit       = err_sub[E-1] || ended;

   // Next state and result for the item in the input register.
   always_comb begin
      active_in     = active_ff;
      steep_in      = steep_ff;
      major_pos_in  = major_pos_ff;
      major_end_in  = major_end_ff;
      minor_pos_in  = minor_pos_ff;
      minor_dir_in  = minor_dir_ff;
      major_span_in = major_span_ff;
      minor_span_in = minor_span_ff;
      error_in      = error_ff;
      run_origin_in = run_origin_ff;
      run_count_in  = run_count_ff;
      color_in      = color_ff;
      out_item_in   = out_item_ff;
      out_valid_in  = out_valid_ff && rsp_stall;

      if (advance) begin
         out_valid_in = 1'b0;
         unique case (stage.item.kind)
            brl_pkg::KIND_START: begin
               active_in     = 1'b1;
               steep_in      = steep;
               major_pos_in  = swap ? maj_b : maj_a;
               major_end_in  = swap ? maj_a : maj_b;
               minor_pos_in  = swap ? min_b : min_a;
               minor_dir_in  = swap ? min_d[S-1] : (!min_d[S-1] && (min_d != '0));
               major_span_in = steep ? abs_dy : abs_dx;
               minor_span_in = steep ? abs_dx : abs_dy;
               error_in      = E'(major_span_in >> 1);
               run_origin_in = swap ? maj_b : maj_a;
               run_count_in  = '0;
               color_in      = stage.item.line_color;
            end
            brl_pkg::KIND_STEP: begin
               if (active_ff) begin
                  major_pos_in = major_next;
                  if (emit) begin
                     out_valid_in = 1'b1;
                     if (steep_ff) begin
                        out_item_in.run_x      = minor_pos_ff[W-1:0];
                        out_item_in.run_y      = run_origin_ff[W-1:0];
                        out_item_in.run_width  = S'(1);
                        out_item_in.run_height = count_next;
                     end else begin
                        out_item_in.run_x      = run_origin_ff[W-1:0];
                        out_item_in.run_y      = minor_pos_ff[W-1:0];
                        out_item_in.run_width  = count_next;
                        out_item_in.run_height = S'(1);
                     end
                     out_item_in.run_color = color_ff;
                     out_item_in.last_run  = ended;
                     error_in      = err_sub + E'(major_span_ff);
                     minor_pos_in  = minor_dir_ff ? (minor_pos_ff + S'(1))
                                                  : (minor_pos_ff - S'(1));
                     run_count_in  = '0;
                     run_origin_in = major_next;
                     if (ended) begin
                        active_in = 1'b0;
                     end
                  end else begin
                     error_in     = err_sub;
                     run_count_in = count_next;
                  end
               end
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Line geometry and the result payload.
   always_ff @(posedge clock) begin
      steep_ff      <= steep_in;
      major_pos_ff  <= major_pos_in;
      major_end_ff  <= major_end_in;
      minor_pos_ff  <= minor_pos_in;
      minor_dir_ff  <= minor_dir_in;
      major_span_ff <= major_span_in;
      minor_span_ff <= minor_span_in;
      error_ff      <= error_in;
      run_origin_ff <= run_origin_in;
      run_count_ff  <= run_count_in;
      color_ff      <= color_in;
      out_item_ff   <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

`default_nettype wire

>>> rtl/bresenham_run_line_core.sv
// Top level of the run-slicing Bresenham line generator.
// A step item passes the input register, then the line engine; any run it ends is held in the result register.
// Throughput: one item per cycle; a start or step is taken every cycle unless a valid result is held by rsp_stall.
// The line engine finishes each item in one pass between the input and result registers.
// Reset clears the line-active flag and both valid flags; a step before any start gives nothing.
`default_nettype none

module bresenham_run_line_core (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire brl_pkg::req_type req_item,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output brl_pkg::rsp_type  rsp_item
);

   brl_pkg::stage_type stage;
   logic               advance;

   // Input register.
   brl_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .advance   (advance),
      .stage     (stage)
   );

   // Line state and result register.
   brl_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire
